[rtl/vmt_pkg.sv]
// Package for the vertex matrix transform unit: fixed-point widths, command
// and status codes, and the payload structs of both channels.
// No dependencies.
`default_nettype none
package vmt_pkg;

  // Fraction bits of every signed fixed-point value.
  localparam int FRAC_BITS = 16;
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  // Unsigned divider: dividend is |value| << FRAC_BITS, two quotient bits per stage.
  localparam int DIV_W      = 32 + FRAC_BITS;
  localparam int DIV_STAGES = (DIV_W + 1) / 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_IDX = 4'd7;

  // Commands; the unused code behaves as the homogeneous command.
  localparam logic [1:0] CMD_DIR   = 2'd0;
  localparam logic [1:0] CMD_POINT = 2'd1;
  localparam logic [1:0] CMD_HOMOG = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_WZERO = 2'd2;

  localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic signed [31:0] w_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic signed [31:0] w_out;
    logic [1:0]         status;
  } out_t;

  // Side information that travels next to the divider lanes.
  typedef struct packed {
    logic [1:0]        cmd;
    logic [3:0][31:0]  res;
    logic              flag;
    logic              wzero;
    logic [2:0]        neg;
  } side_t;

endpackage
`default_nettype wire

[rtl/vmt_div_lane.sv]
// Pipelined unsigned restoring divider, two quotient bits per stage.
// Depends on vmt_pkg for the dividend width and stage count.
`default_nettype none
module vmt_div_lane import vmt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DIV_W-1:0] num_i,
  input  wire logic [31:0]      den_i,
  output logic [DIV_W-1:0]      quo_o
);

  logic [32:0]      rem_r [DIV_STAGES];
  logic [DIV_W-1:0] quo_r [DIV_STAGES];
  logic [31:0]      den_r [DIV_STAGES];

  for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stg
    logic [32:0]      r_in;
    logic [DIV_W-1:0] q_in;
    logic [31:0]      d_in;
    logic [32:0]      r_nxt;
    logic [DIV_W-1:0] q_nxt;

    if (st == 0) begin : g_first
      assign r_in = '0;
      assign q_in = num_i;
      assign d_in = den_i;
    end else begin : g_rest
      assign r_in = rem_r[st-1];
      assign q_in = quo_r[st-1];
      assign d_in = den_r[st-1];
    end

    // The dividend bits shift out of the top of q while quotient bits enter below.
    always_comb begin
      r_nxt = r_in;
      q_nxt = q_in;
      for (int k = 0; k < 2; k++) begin
        if (st * 2 + k < DIV_W) begin
          r_nxt = {r_nxt[31:0], q_nxt[DIV_W-1]};
          q_nxt = {q_nxt[DIV_W-2:0], 1'b0};
          if (r_nxt >= {1'b0, d_in}) begin
            r_nxt    = r_nxt - {1'b0, d_in};
            q_nxt[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[st] <= r_nxt;
        quo_r[st] <= q_nxt;
        den_r[st] <= d_in;
      end
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule
`default_nettype wire

[rtl/vertex_matrix_transform_unit.sv]
// Top level of the vertex matrix transform unit: 4x4 matrix transform with
// perspective divide. Depends on vmt_pkg and vmt_div_lane.
`default_nettype none
// Channel   Direction  Ports                              Transfer when
// input     in         in_valid, in_stall, in_data        in_valid && !in_stall
// result    out        out_valid, out_stall, out_data     out_valid && !out_stall
// config    in         cfg_we, cfg_index, cfg_data        cfg_we (index above 7 ignored)
//
// One vertex can enter every cycle unless a stall on the result side holds the
// pipeline; the perspective divide is done by the pipelined divider after stage 4.
// Reset (rst_n, synchronous) clears the valid bits and loads the identity matrix.
// A stall on the result side freezes the whole pipeline; a one-entry skid buffer
// at the input takes the transfer already offered, so in_stall is a register.
module vertex_matrix_transform_unit import vmt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  // Matrix storage, m[row][col].
  logic signed [31:0] mat_r [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mat_r[r][c] <= (r == c) ? ONE_Q : '0;
        end
      end
    end else if (cfg_we && cfg_index <= CFG_LAST_IDX) begin
      mat_r[cfg_index[2:1]][{cfg_index[0], 1'b0}] <= cfg_data[31:0];
      mat_r[cfg_index[2:1]][{cfg_index[0], 1'b1}] <= cfg_data[63:32];
    end
  end

  // The whole pipeline advances unless a finished result is held by the sink.
  logic en;
  assign en = !out_valid || !out_stall;

  // Input skid buffer.
  logic skid_full_r;
  in_t  skid_r;
  logic in_take;
  assign in_stall = skid_full_r;
  assign in_take  = in_valid && !skid_full_r;

  // Stage 1: registered input item.
  logic s1_valid_r;
  in_t  s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= skid_full_r || in_take;
      skid_full_r <= 1'b0;
    end else if (in_take) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= skid_full_r ? skid_r : in_data;
    end else if (in_take) begin
      skid_r <= in_data;
    end
  end

  // Stage 2: sixteen exact products. A direction leaves out row 3, a point
  // uses 1.0 as its fourth component.
  logic signed [31:0] a_vec [4];
  logic signed [63:0] prod_nxt [4][4];
  logic signed [63:0] prod_r [4][4];
  logic               s2_valid_r;
  logic [1:0]         s2_cmd_r;

  always_comb begin
    a_vec[0] = s1_r.x_in;
    a_vec[1] = s1_r.y_in;
    a_vec[2] = s1_r.z_in;
    case (s1_r.cmd)
      CMD_DIR:   a_vec[3] = '0;
      CMD_POINT: a_vec[3] = ONE_Q;
      default:   a_vec[3] = s1_r.w_in;
    endcase
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_nxt[r][c] = a_vec[r] * mat_r[r][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cmd_r <= s1_r.cmd;
      prod_r   <= prod_nxt;
    end
  end

  // Stage 3: column sums at full precision, floored to the fraction and clamped.
  logic signed [65:0] col_sum [4];
  logic signed [65:0] col_shr [4];
  logic signed [31:0] res_nxt [4];
  logic [3:0]         col_sat;
  logic               s3_valid_r;
  logic [1:0]         s3_cmd_r;
  logic signed [31:0] s3_res_r [4];
  logic               s3_flag_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      col_sum[c] = 66'(prod_r[0][c]) + 66'(prod_r[1][c])
                 + 66'(prod_r[2][c]) + 66'(prod_r[3][c]);
      col_shr[c] = col_sum[c] >>> FRAC_BITS;
      if (col_shr[c] > 66'(INT32_MAX)) begin
        res_nxt[c] = INT32_MAX;
        col_sat[c] = 1'b1;
      end else if (col_shr[c] < 66'(INT32_MIN)) begin
        res_nxt[c] = INT32_MIN;
        col_sat[c] = 1'b1;
      end else begin
        res_nxt[c] = col_shr[c][31:0];
        col_sat[c] = 1'b0;
      end
    end
    // A direction has no w column.
    if (s2_cmd_r == CMD_DIR) begin
      res_nxt[3] = '0;
      col_sat[3] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_cmd_r  <= s2_cmd_r;
      s3_res_r  <= res_nxt;
      s3_flag_r <= |col_sat;
    end
  end

  // Stage 4: magnitudes and signs for the divider.
  logic              s4_valid_r;
  side_t             s4_side_r;
  logic [DIV_W-1:0]  s4_num_r [3];
  logic [31:0]       s4_den_r;
  side_t             side_nxt;

  always_comb begin
    side_nxt.cmd   = s3_cmd_r;
    side_nxt.flag  = s3_flag_r;
    side_nxt.wzero = (s3_res_r[3] == '0);
    for (int c = 0; c < 4; c++) begin
      side_nxt.res[c] = s3_res_r[c];
    end
    for (int c = 0; c < 3; c++) begin
      side_nxt.neg[c] = s3_res_r[c][31] ^ s3_res_r[3][31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= side_nxt;
      for (int c = 0; c < 3; c++) begin
        s4_num_r[c] <= {(s3_res_r[c][31] ? 32'(-s3_res_r[c]) : 32'(s3_res_r[c])),
                        FRAC_BITS'(0)};
      end
      s4_den_r <= s3_res_r[3][31] ? 32'(-s3_res_r[3]) : 32'(s3_res_r[3]);
    end
  end

  // Divider lanes for x, y and z, with the side information alongside.
  logic [DIV_W-1:0] quo [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    vmt_div_lane u_div (
      .clk   (clk),
      .en    (en),
      .num_i (s4_num_r[c]),
      .den_i (s4_den_r),
      .quo_o (quo[c])
    );
  end

  logic  dv_valid_r [DIV_STAGES];
  side_t dv_side_r  [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_valid_r[s] <= 1'b0;
      end
    end else if (en) begin
      dv_valid_r[0] <= s4_valid_r;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dv_valid_r[s] <= dv_valid_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0] <= s4_side_r;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dv_side_r[s] <= dv_side_r[s-1];
      end
    end
  end

  // Final stage: sign, clamp and status into the output register.
  side_t              fin;
  logic signed [31:0] comp [3];
  logic [2:0]         q_sat;
  out_t               out_nxt;

  assign fin = dv_side_r[DIV_STAGES-1];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q_sat[c] = 1'b0;
      comp[c]  = fin.res[c];
      if (fin.cmd == CMD_POINT) begin
        if (fin.wzero) begin
          if (fin.res[c][31]) begin
            comp[c] = INT32_MIN;
          end else if (fin.res[c] != '0) begin
            comp[c] = INT32_MAX;
          end else begin
            comp[c] = '0;
          end
        end else if (fin.neg[c]) begin
          if (quo[c] > DIV_W'(33'h0_8000_0000)) begin
            comp[c]  = INT32_MIN;
            q_sat[c] = 1'b1;
          end else begin
            comp[c] = 32'(-quo[c]);
          end
        end else begin
          if (quo[c] > DIV_W'(32'h7FFF_FFFF)) begin
            comp[c]  = INT32_MAX;
            q_sat[c] = 1'b1;
          end else begin
            comp[c] = quo[c][31:0];
          end
        end
      end
    end
    out_nxt.x_out = comp[0];
    out_nxt.y_out = comp[1];
    out_nxt.z_out = comp[2];
    out_nxt.w_out = fin.res[3];
    if (fin.cmd == CMD_POINT && fin.wzero) begin
      out_nxt.status = ST_WZERO;
    end else if (fin.flag || (|q_sat)) begin
      out_nxt.status = ST_SAT;
    end else begin
      out_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_nxt;
    end
  end

endmodule
`default_nettype wire
